/* sv/lgs_pkg.sv */
// lgs_pkg: shared types, register codes and helpers of the Life generation stencil.
// Depends on nothing; used by lgs_col_cell, lgs_rule and life_generation_stencil.
`timescale 1ns / 1ps
`default_nettype none

package lgs_pkg;

	localparam int DIM_W   = 11;    // width of board_width / board_height
	localparam int DIM_MIN = 3;
	localparam int DIM_MAX = 2047;  // largest value an 11-bit register holds
	localparam logic [DIM_W-1:0] DIM_RESET = 11'd400;

	localparam int IDX_W = 1;

	typedef enum logic [IDX_W-1:0] {
		REG_BOARD_WIDTH  = 1'b0,
		REG_BOARD_HEIGHT = 1'b1
	} reg_idx_t;

	// one column of the 3x3 window
	typedef struct packed {
		logic lower;
		logic middle;
		logic upper;
	} col_t;

	// column plus its live count, handed from cell to cell
	typedef struct packed {
		col_t       bits;
		logic [1:0] sum;
	} tap_t;

	// per-item control carried alongside the line store read
	typedef struct packed {
		logic produce;
		logic interior;
		logic last;
	} ctl_t;

	function automatic logic [1:0] col_sum(col_t c);
		return {1'b0, c.upper} + {1'b0, c.middle} + {1'b0, c.lower};
	endfunction

	function automatic logic [DIM_W-1:0] clamp_dim(logic [DIM_W-1:0] v,
			logic [DIM_W-1:0] cap);
		if (v < DIM_W'(DIM_MIN)) begin
			return DIM_W'(DIM_MIN);
		end else if (v > cap) begin
			return cap;
		end
		return v;
	endfunction

endpackage

`default_nettype wire

/* sv/life_generation_stencil.sv */
// life_generation_stencil: streaming Conway Life (B3/S23) generation, top level.
// Depends on lgs_pkg, lgs_ram, lgs_col_cell and lgs_rule.
`timescale 1ns / 1ps
`default_nettype none

// The board streams in raster order, one cell per item (cmd = 0), and must be
// followed by exactly board_width+1 drain items (cmd = 1) so that the last
// results flush. The block takes one item per clock unless it stalls as below. An
// item is taken into a read stage that addresses the line store RAM; as it leaves
// that stage it joins the window and its result, if any, is loaded into the result
// register, from which it is offered.
// Item k of a frame returns the next state of cell k-board_width-1; the
// first board_width+1 items of a frame return nothing. The result of the very
// last cell carries frame_end. Cells of the first and last row and column are
// passed through unchanged. The only stall is a result waiting in the output
// register while the read stage holds another item that makes a result.
// board_width and board_height are clamped to 3..MAX_WIDTH / MAX_HEIGHT (at most 2047); a
// write to either restarts the frame (line store contents are kept). The line
// store is not cleared at reset: bits read before they are written only ever
// reach pass-through border results.

module life_generation_stencil #(
	parameter int MAX_WIDTH  = 1024,
	parameter int MAX_HEIGHT = 1024
) (
	input  wire logic                      clk,
	input  wire logic                      arst_n,

	input  wire logic                      cfg_we,
	input  wire logic [lgs_pkg::IDX_W-1:0] cfg_index,
	input  wire logic [lgs_pkg::DIM_W-1:0] cfg_data,

	input  wire logic                      item_valid,
	output logic                           item_ready,
	input  wire logic                      cmd,
	input  wire logic                      cell_req,

	output logic                           res_valid,
	input  wire logic                      res_ready,
	output logic                           next_cell,
	output logic                           frame_end
);

	localparam int DW = lgs_pkg::DIM_W;
	localparam int CW = $clog2(MAX_WIDTH);       // column counter / RAM address
	localparam int RW = $clog2(MAX_HEIGHT + 2);  // row counter, reaches height+1
	localparam int XW = (CW > DW) ? CW : DW;     // column compare width
	localparam int YW = ((RW > DW) ? RW : DW) + 1; // row compare width

	localparam logic [DW-1:0] WIDTH_CAP =
		DW'((MAX_WIDTH > lgs_pkg::DIM_MAX) ? lgs_pkg::DIM_MAX : MAX_WIDTH);
	localparam logic [DW-1:0] HEIGHT_CAP =
		DW'((MAX_HEIGHT > lgs_pkg::DIM_MAX) ? lgs_pkg::DIM_MAX : MAX_HEIGHT);

	// configuration, stored already clamped
	logic [DW-1:0] width_q;
	logic [DW-1:0] height_q;

	// raster position of the next item
	logic [CW-1:0] col_q;
	logic [RW-1:0] row_q;

	// read stage
	logic          s1_valid_q;
	logic          cell_s1;
	logic [CW-1:0] addr_s1;
	lgs_pkg::ctl_t ctl_s1;

	// result register
	logic          res_valid_q;
	logic          next_cell_q;
	logic          frame_end_q;

	logic          accept;
	logic          adv1;
	logic          cell_in;
	lgs_pkg::ctl_t ctl_in;
	logic [XW-1:0] col_x;
	logic [XW-1:0] w_x;
	logic [YW-1:0] row_x;
	logic [YW-1:0] h_x;
	logic          col_wrap;
	logic [1:0]    line_rd;
	lgs_pkg::tap_t tap_new;
	lgs_pkg::tap_t tap0_q;
	lgs_pkg::tap_t tap1_q;
	logic          win_clear;
	logic          rule_out;

	assign accept  = item_valid && item_ready;
	assign cell_in = cmd ? 1'b0 : cell_req;  // a drain shifts in a dead cell

	// position decode
	assign col_x    = XW'(col_q);
	assign w_x      = XW'(width_q);
	assign row_x    = YW'(row_q);
	assign h_x      = YW'(height_q);
	assign col_wrap = (col_x == w_x - XW'(1));

	// results start one row and one column into the frame; the frame ends at
	// column 0 of row height+1
	assign ctl_in.produce  = (row_q >= RW'(2)) || ((row_q == RW'(1)) && (col_q != '0));
	assign ctl_in.last     = (row_x == h_x + YW'(1)) && (col_q == '0);
	assign ctl_in.interior = (col_x >= XW'(2)) && (row_q >= RW'(2))
		&& (row_x + YW'(1) <= h_x);

	// configuration and raster counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= lgs_pkg::clamp_dim(lgs_pkg::DIM_RESET, WIDTH_CAP);
			height_q <= lgs_pkg::clamp_dim(lgs_pkg::DIM_RESET, HEIGHT_CAP);
			col_q    <= '0;
			row_q    <= '0;
		end else begin
			priority if (cfg_we) begin
				unique case (lgs_pkg::reg_idx_t'(cfg_index))
					lgs_pkg::REG_BOARD_WIDTH: begin
						width_q <= lgs_pkg::clamp_dim(cfg_data, WIDTH_CAP);
					end
					lgs_pkg::REG_BOARD_HEIGHT: begin
						height_q <= lgs_pkg::clamp_dim(cfg_data, HEIGHT_CAP);
					end
				endcase
				col_q <= '0;
				row_q <= '0;
			end else if (accept) begin
				priority if (ctl_in.last) begin
					col_q <= '0;
					row_q <= '0;
				end else if (col_wrap) begin
					col_q <= '0;
					row_q <= row_q + RW'(1);
				end else begin
					col_q <= col_q + CW'(1);
				end
			end else begin
				col_q <= col_q;
				row_q <= row_q;
			end
		end
	end

	// read stage moves on unless it holds a result that has nowhere to go
	assign adv1       = s1_valid_q && (!ctl_s1.produce || !res_valid_q || res_ready);
	assign item_ready = !s1_valid_q || adv1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else begin
			priority if (accept) begin
				s1_valid_q <= 1'b1;
			end else if (adv1) begin
				s1_valid_q <= 1'b0;
			end else begin
				s1_valid_q <= s1_valid_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cell_s1 <= cell_in;
			addr_s1 <= col_q;
			ctl_s1  <= ctl_in;
		end
	end

	// line store: bit 1 upper row, bit 0 middle row. Read on accept, written
	// back when the item leaves the read stage (middle moves up, new cell in).
	lgs_ram #(
		.WIDTH(2),
		.DEPTH(MAX_WIDTH)
	) u_line_store (
		.clk  (clk),
		.we   (adv1),
		.waddr(addr_s1),
		.wdata({line_rd[0], cell_s1}),
		.re   (accept),
		.raddr(col_q),
		.rdata(line_rd)
	);

	// incoming window column, then two cells holding the older columns
	assign tap_new.bits.upper  = line_rd[1];
	assign tap_new.bits.middle = line_rd[0];
	assign tap_new.bits.lower  = cell_s1;
	assign tap_new.sum         = lgs_pkg::col_sum(tap_new.bits);

	// window clears after the last cell of a frame and on a register write
	assign win_clear = (adv1 && ctl_s1.last) || cfg_we;

	lgs_col_cell u_cell0 (
		.clk   (clk),
		.arst_n(arst_n),
		.shift (adv1),
		.clear (win_clear),
		.tap_in(tap_new),
		.tap_q (tap0_q)
	);

	lgs_col_cell u_cell1 (
		.clk   (clk),
		.arst_n(arst_n),
		.shift (adv1),
		.clear (win_clear),
		.tap_in(tap0_q),
		.tap_q (tap1_q)
	);

	// the window after this item's shift is {incoming, cell0, cell1}; its
	// centre sits in cell0. At column 0 that centre is the wrapped last-column
	// cell, which is a border and passes through.
	lgs_rule u_rule (
		.newest    (tap_new),
		.centre_col(tap0_q),
		.oldest    (tap1_q),
		.interior  (ctl_s1.interior),
		.next_state(rule_out)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else begin
			priority if (adv1 && ctl_s1.produce) begin
				res_valid_q <= 1'b1;
			end else if (res_ready) begin
				res_valid_q <= 1'b0;
			end else begin
				res_valid_q <= res_valid_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv1 && ctl_s1.produce) begin
			next_cell_q <= rule_out;
			frame_end_q <= ctl_s1.last;
		end
	end

	assign res_valid = res_valid_q;
	assign next_cell = next_cell_q;
	assign frame_end = frame_end_q;

`ifndef SYNTHESIS
	// raster position stays inside the configured board
	a_col_bound: assert property (@(posedge clk) disable iff (!arst_n)
		col_x < w_x)
		else $error("column counter beyond board width");

	a_row_bound: assert property (@(posedge clk) disable iff (!arst_n)
		row_x <= h_x + YW'(1))
		else $error("row counter beyond board height plus one");

	// input stalls only behind a result waiting on a full output register
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!item_ready |-> (s1_valid_q && ctl_s1.produce && res_valid_q && !res_ready))
		else $error("input stalled without a blocked result");

	// the frame end item always produces a result, and interior cells too
	a_last_produces: assert property (@(posedge clk) disable iff (!arst_n)
		(s1_valid_q && (ctl_s1.last || ctl_s1.interior)) |-> ctl_s1.produce)
		else $error("frame end or interior item without a result");

	// a result that leaves the read stage is offered on the next clock
	a_result_loaded: assert property (@(posedge clk) disable iff (!arst_n)
		(adv1 && ctl_s1.produce) |=> res_valid_q)
		else $error("result lost between read stage and output");
`endif

endmodule

`default_nettype wire

/* sv/lgs_ram.sv */
// lgs_ram: generic simple dual-port RAM, one write and one registered read port.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module lgs_ram #(
	parameter int WIDTH = 2,
	parameter int DEPTH = 1024
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

/* sv/lgs_col_cell.sv */
// lgs_col_cell: one window column cell; holds a column and its count, shifts on.
// Depends on lgs_pkg.
`timescale 1ns / 1ps
`default_nettype none

module lgs_col_cell (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          shift,
	input  wire logic          clear,
	input  wire lgs_pkg::tap_t tap_in,
	output lgs_pkg::tap_t      tap_q
);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tap_q <= '0;
		end else begin
			priority if (clear) begin
				tap_q <= '0;
			end else if (shift) begin
				tap_q <= tap_in;
			end else begin
				tap_q <= tap_q;
			end
		end
	end

endmodule

`default_nettype wire

/* sv/lgs_rule.sv */
// lgs_rule: B3/S23 decision from three window columns; borders pass through.
// Depends on lgs_pkg.
`timescale 1ns / 1ps
`default_nettype none

module lgs_rule (
	input  wire lgs_pkg::tap_t newest,
	input  wire lgs_pkg::tap_t centre_col,
	input  wire lgs_pkg::tap_t oldest,
	input  wire logic          interior,
	output logic               next_state
);

	logic       centre;
	logic [3:0] neighbors;

	assign centre = centre_col.bits.middle;

	// nine-cell count minus the centre
	assign neighbors = {2'b00, newest.sum} + {2'b00, centre_col.sum}
		+ {2'b00, oldest.sum} - {3'b000, centre};

	always_comb begin
		if (interior) begin
			next_state = (neighbors == 4'd3) || ((neighbors == 4'd2) && centre);
		end else begin
			next_state = centre;
		end
	end

endmodule

`default_nettype wire
